[src/ps2_scancode_to_hid_report_unit_macros.svh]
// ============================================================================
// PS/2 to HID report unit assertion macros
// Shared concurrent assertion forms for the checker.
// ============================================================================
`ifndef PS2_SCANCODE_TO_HID_REPORT_UNIT_MACROS_SVH
`define PS2_SCANCODE_TO_HID_REPORT_UNIT_MACROS_SVH

// same-cycle implication
`define PS2HID_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ps2hid assertion failed");

// next-cycle implication
`define PS2HID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ps2hid assertion failed");

`endif

[src/ps2hid_pkg.sv]
// ============================================================================
// PS/2 to HID report package
// Types, prefix codes and scan code translation tables.
// ============================================================================
package ps2hid_pkg;

	typedef logic [7:0]  code_byte_t;
	typedef logic [10:0] xlat_t;

	localparam code_byte_t PREFIX_EXT = 8'hE0;
	localparam code_byte_t PREFIX_REL = 8'hF0;
	localparam code_byte_t USAGE_MAX  = 8'h6F;
	localparam int         MOD_BIT    = 10;
	localparam int         NORMAL_LEN = 132;
	localparam int         OUT_SLOTS  = 6;

	localparam xlat_t NORMAL_ROM [NORMAL_LEN] = '{
		11'h003, 11'h042, 11'h000, 11'h03E, 11'h03C, 11'h03A, 11'h03B, 11'h045,
		11'h000, 11'h043, 11'h041, 11'h03F, 11'h03D, 11'h02B, 11'h035, 11'h067,
		11'h000, 11'h000, 11'h402, 11'h404, 11'h401, 11'h014, 11'h01E, 11'h000,
		11'h06A, 11'h000, 11'h01D, 11'h016, 11'h004, 11'h01A, 11'h01F, 11'h000,
		11'h000, 11'h006, 11'h01B, 11'h007, 11'h008, 11'h021, 11'h020, 11'h000,
		11'h000, 11'h02C, 11'h019, 11'h009, 11'h017, 11'h015, 11'h022, 11'h000,
		11'h000, 11'h011, 11'h005, 11'h00B, 11'h00A, 11'h01C, 11'h023, 11'h000,
		11'h000, 11'h000, 11'h010, 11'h00D, 11'h018, 11'h024, 11'h025, 11'h000,
		11'h000, 11'h036, 11'h00E, 11'h00C, 11'h012, 11'h027, 11'h026, 11'h000,
		11'h000, 11'h037, 11'h038, 11'h00F, 11'h033, 11'h013, 11'h02D, 11'h000,
		11'h000, 11'h000, 11'h034, 11'h000, 11'h02F, 11'h02E, 11'h000, 11'h000,
		11'h039, 11'h420, 11'h028, 11'h030, 11'h000, 11'h032, 11'h000, 11'h000,
		11'h000, 11'h064, 11'h000, 11'h000, 11'h000, 11'h000, 11'h02A, 11'h000,
		11'h000, 11'h059, 11'h000, 11'h05C, 11'h06C, 11'h000, 11'h000, 11'h048,
		11'h06F, 11'h063, 11'h05A, 11'h05D, 11'h05E, 11'h06D, 11'h029, 11'h068,
		11'h044, 11'h057, 11'h05B, 11'h056, 11'h055, 11'h06E, 11'h069, 11'h000,
		11'h000, 11'h000, 11'h000, 11'h040
	};

	function automatic xlat_t normal_lookup(input code_byte_t b);
		xlat_t r;
		r = '0;
		if (int'(b) < NORMAL_LEN) begin
			r = NORMAL_ROM[b];
		end
		return r;
	endfunction

	function automatic xlat_t ext_lookup(input code_byte_t b);
		xlat_t r;
		unique case (b)
			8'h11:   r = 11'h440;
			8'h14:   r = 11'h410;
			8'h1F:   r = 11'h408;
			8'h2F:   r = 11'h065;
			8'h37:   r = 11'h066;
			8'h4A:   r = 11'h054;
			8'h5A:   r = 11'h058;
			8'h69:   r = 11'h04D;
			8'h6B:   r = 11'h050;
			8'h6C:   r = 11'h04A;
			8'h70:   r = 11'h06B;
			8'h71:   r = 11'h04C;
			8'h72:   r = 11'h051;
			8'h74:   r = 11'h04F;
			8'h75:   r = 11'h052;
			8'h7A:   r = 11'h04E;
			8'h7C:   r = 11'h046;
			8'h7D:   r = 11'h04B;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[src/ps2hid_if.sv]
// ============================================================================
// PS/2 to HID report channel interfaces
// Valid/ready channels for scan code bytes and HID reports.
// ============================================================================
interface ps2hid_scan_if;
	import ps2hid_pkg::*;

	logic       valid;
	logic       ready;
	code_byte_t scan_byte;

	modport source (output valid, output scan_byte, input ready);
	modport sink   (input valid, input scan_byte, output ready);
endinterface

interface ps2hid_report_if;
	import ps2hid_pkg::*;

	logic       valid;
	logic       ready;
	code_byte_t modifier_mask;
	code_byte_t slot_0;
	code_byte_t slot_1;
	code_byte_t slot_2;
	code_byte_t slot_3;
	code_byte_t slot_4;
	code_byte_t slot_5;

	modport source (output valid, output modifier_mask, output slot_0, output slot_1,
		output slot_2, output slot_3, output slot_4, output slot_5, input ready);
	modport sink   (input valid, input modifier_mask, input slot_0, input slot_1,
		input slot_2, input slot_3, input slot_4, input slot_5, output ready);
endinterface

[src/ps2_scancode_to_hid_report_unit.sv]
// ============================================================================
// PS/2 set-2 scan code to HID boot keyboard report unit
// Translates scan code bytes and keeps the modifier byte and report slots.
// ============================================================================
// Path: an accepted byte goes into the input register, then through the table lookup
// and slot compare/update into the report register. Throughput: one byte per cycle
// while a held report is not stalled by report.ready; the input register and the
// report register then stall together.
// Reset clears prefix marks, modifiers, slots and both pipeline valid flags.
module ps2_scancode_to_hid_report_unit #(
	parameter int REPORT_SLOTS = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	ps2hid_scan_if.sink      scan,
	ps2hid_report_if.source  report
);
	import ps2hid_pkg::*;

	logic       valid_s1;
	code_byte_t byte_s1;
	logic       out_free;
	logic       s1_fire;

	logic       ext_q;
	logic       rel_q;
	code_byte_t mod_q;
	code_byte_t slots_q [REPORT_SLOTS];

	logic       ext_d;
	logic       rel_d;
	code_byte_t mod_d;
	code_byte_t slots_d [REPORT_SLOTS];
	xlat_t      code;
	code_byte_t key;
	logic       changed;
	logic       stop;

	code_byte_t rpt_d [OUT_SLOTS];
	logic       rpt_valid_q;
	code_byte_t rpt_mod_q;
	code_byte_t rpt_slot_q [OUT_SLOTS];

	assign out_free   = !rpt_valid_q || report.ready;
	assign s1_fire    = valid_s1 && out_free;
	assign scan.ready = !valid_s1 || out_free;

	always_comb begin
		ext_d   = ext_q;
		rel_d   = rel_q;
		mod_d   = mod_q;
		slots_d = slots_q;
		changed = 1'b0;
		stop    = 1'b0;
		code    = ext_q ? ext_lookup(byte_s1) : normal_lookup(byte_s1);
		key     = code[7:0];
		if (byte_s1 == PREFIX_EXT) begin
			ext_d = 1'b1;
		end else if (byte_s1 == PREFIX_REL) begin
			rel_d = 1'b1;
		end else begin
			ext_d = 1'b0;
			rel_d = 1'b0;
			if (code[MOD_BIT]) begin
				mod_d   = rel_q ? (mod_q & ~key) : (mod_q | key);
				changed = 1'b1;
			end else if (key != '0) begin
				if (rel_q) begin
					for (int i = 0; i < REPORT_SLOTS; i++) begin
						if (slots_q[i] == key) begin
							slots_d[i] = '0;
							changed    = 1'b1;
						end
					end
				end else begin
					for (int i = 0; i < REPORT_SLOTS; i++) begin
						if (!stop) begin
							if (slots_q[i] == key) begin
								stop = 1'b1;
							end else if (slots_q[i] == '0) begin
								slots_d[i] = key;
								changed    = 1'b1;
								stop       = 1'b1;
							end
						end
					end
				end
			end
		end
	end

	for (genvar k = 0; k < OUT_SLOTS; k++) begin : g_rpt
		if (k < REPORT_SLOTS) begin : g_used
			assign rpt_d[k] = slots_d[k];
		end else begin : g_unused
			assign rpt_d[k] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rpt_valid_q <= 1'b0;
			ext_q       <= 1'b0;
			rel_q       <= 1'b0;
			mod_q       <= '0;
			for (int i = 0; i < REPORT_SLOTS; i++) begin
				slots_q[i] <= '0;
			end
		end else begin
			if (scan.valid && scan.ready) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				rpt_valid_q <= changed;
				ext_q       <= ext_d;
				rel_q       <= rel_d;
				mod_q       <= mod_d;
				slots_q     <= slots_d;
			end else if (report.ready) begin
				rpt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			byte_s1 <= scan.scan_byte;
		end
		if (s1_fire && changed) begin
			rpt_mod_q  <= mod_d;
			rpt_slot_q <= rpt_d;
		end
	end

	assign report.valid         = rpt_valid_q;
	assign report.modifier_mask = rpt_mod_q;
	assign report.slot_0        = rpt_slot_q[0];
	assign report.slot_1        = rpt_slot_q[1];
	assign report.slot_2        = rpt_slot_q[2];
	assign report.slot_3        = rpt_slot_q[3];
	assign report.slot_4        = rpt_slot_q[4];
	assign report.slot_5        = rpt_slot_q[5];

endmodule

[src/ps2hid_chk.sv]
// ============================================================================
// PS/2 to HID report unit port checker
// Watches the top-level channels and attaches to the unit by bind.
// ============================================================================
`include "ps2_scancode_to_hid_report_unit_macros.svh"

module ps2hid_chk (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   scan_valid,
	input logic                   scan_ready,
	input logic                   report_valid,
	input logic                   report_ready,
	input ps2hid_pkg::code_byte_t slot_0,
	input ps2hid_pkg::code_byte_t slot_1,
	input ps2hid_pkg::code_byte_t slot_2,
	input ps2hid_pkg::code_byte_t slot_3,
	input ps2hid_pkg::code_byte_t slot_4,
	input ps2hid_pkg::code_byte_t slot_5
);
	import ps2hid_pkg::*;

	`PS2HID_ASSERT_NEXT(a_report_hold, clk, arst_n, report_valid && !report_ready, report_valid)
	`PS2HID_ASSERT_IMPL(a_report_after_byte, clk, arst_n, $rose(report_valid),
		$past(scan_valid && scan_ready, 2))
	`PS2HID_ASSERT_IMPL(a_usage_range, clk, arst_n, report_valid,
		slot_0 <= USAGE_MAX && slot_1 <= USAGE_MAX && slot_2 <= USAGE_MAX &&
		slot_3 <= USAGE_MAX && slot_4 <= USAGE_MAX && slot_5 <= USAGE_MAX)
	`PS2HID_ASSERT_NEXT(a_slot_hold, clk, arst_n, report_valid && !report_ready,
		$stable(slot_0) && $stable(slot_1) && $stable(slot_2) &&
		$stable(slot_3) && $stable(slot_4) && $stable(slot_5))

endmodule

bind ps2_scancode_to_hid_report_unit ps2hid_chk u_ps2hid_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.scan_valid   (scan.valid),
	.scan_ready   (scan.ready),
	.report_valid (report.valid),
	.report_ready (report.ready),
	.slot_0       (report.slot_0),
	.slot_1       (report.slot_1),
	.slot_2       (report.slot_2),
	.slot_3       (report.slot_3),
	.slot_4       (report.slot_4),
	.slot_5       (report.slot_5)
);
